@@ hdl/lvl_pkg.sv @@
package lvl_pkg;

    // block limits and scaling
    localparam int MAX_CHANNELS    = 8;
    localparam int MAX_BLOCK       = 4096;
    localparam int FULL_SCALE      = 32767;
    localparam int LEVEL_FRAC_BITS = 8;
    localparam int LVL_LIMIT       = 100 << LEVEL_FRAC_BITS;

    // rounding terms for the two scaling divisions
    localparam int PK_HALF  = FULL_SCALE / 2;
    localparam int RMS_DEN  = FULL_SCALE << 8;
    localparam int RMS_HALF = RMS_DEN / 2;

    // serial multiplier and divider sizes
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 62;
    localparam int DIV_D_W = 24;

    // register map
    localparam int APB_AW = 5;
    localparam logic [2:0] REG_NUM_CH  = 3'd0;
    localparam logic [2:0] REG_SEL_CH  = 3'd1;
    localparam logic [2:0] REG_BLOCK   = 3'd2;
    localparam logic [2:0] REG_SMOOTH  = 3'd3;
    localparam logic [2:0] REG_ATTACK  = 3'd4;
    localparam logic [2:0] REG_RELEASE = 3'd5;

endpackage

@@ hdl/lvl_mul.sv @@
module lvl_mul import lvl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_prod
);

    logic               r_busy;
    logic               r_done;
    logic [MUL_P_W-1:0] r_ma;
    logic [MUL_B_W-1:0] r_mb;
    logic [MUL_P_W-1:0] r_acc;

    // shift-add, one multiplier bit per cycle, stops when no bits remain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ma   <= MUL_P_W'(i_a);
                r_mb   <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_mb == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_mb[0]) r_acc <= r_acc + r_ma;
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ hdl/lvl_div.sv @@
module lvl_div import lvl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W:0]   w_trial;
    logic               w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_q[DIV_N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIV_N_W - 1);
            end else if (r_busy) begin
                r_rem <= w_ge ? DIV_D_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_D_W-1:0];
                r_q   <= {r_q[DIV_N_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

@@ hdl/block_peak_rms_level_meter_top.sv @@
// channel   dir   signals                                         beat when
// input     in    i_in_valid/o_in_ready, i_sample, i_channel_index valid & ready
// output    out   o_out_valid/i_out_ready, o_peak_level, o_rms_level valid & ready
// config    in    psel/penable/pwrite/paddr/pwdata/prdata/pready  psel & penable & pwrite
//
// a discarded sample is taken without leaving idle; a kept sample holds input off
// while the bit-serial multiplier squares its magnitude
// the end of a block adds three divisions, a 24-step square root and two to six
// serial multiplies
// synchronous active-low reset clears control, accumulators and held levels
// a finished result waits in the output register while the next sample is taken
module block_peak_rms_level_meter_top import lvl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic signed [15:0] i_sample,
    input  logic [2:0]        i_channel_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [14:0]       o_peak_level,
    output logic [14:0]       o_rms_level,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQ      = 4'd1;
    localparam logic [3:0] S_PMUL    = 4'd2;
    localparam logic [3:0] S_DIV_PK  = 4'd3;
    localparam logic [3:0] S_DIV_M   = 4'd4;
    localparam logic [3:0] S_SQRT    = 4'd5;
    localparam logic [3:0] S_RMUL    = 4'd6;
    localparam logic [3:0] S_DIV_RMS = 4'd7;
    localparam logic [3:0] S_SM1     = 4'd8;
    localparam logic [3:0] S_SM2     = 4'd9;
    localparam logic [3:0] S_SM3     = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    function automatic logic [16:0] coeff_sat(input logic [16:0] c);
        return (c > 17'h10000) ? 17'h10000 : c;
    endfunction

    function automatic logic [14:0] lvl_clamp(input logic [16:0] v);
        return (v > 17'(LVL_LIMIT)) ? 15'(LVL_LIMIT) : v[14:0];
    endfunction

    // configuration registers
    logic [3:0]  r_num_ch;
    logic [3:0]  r_sel_ch;
    logic [12:0] r_blk;
    logic        r_smooth;
    logic [16:0] r_attack;
    logic [16:0] r_release;

    // control and accumulators
    logic [3:0]  r_state;
    logic [15:0] r_peak;
    logic [45:0] r_sum;
    logic [15:0] r_count;
    logic        r_end;
    logic [14:0] r_pk_held;
    logic [14:0] r_rms_held;
    logic [14:0] r_raw_pk;
    logic [14:0] r_raw_rms;
    logic        r_which;
    logic [16:0] r_c;
    logic [31:0] r_tmp;

    // square root datapath
    logic [47:0] r_rad;
    logic [23:0] r_root;
    logic [25:0] r_srem;
    logic [4:0]  r_scnt;

    // output register
    logic        r_out_valid;
    logic [14:0] r_peak_out;
    logic [14:0] r_rms_out;

    // shared serial units
    logic               r_mul_start;
    logic [MUL_A_W-1:0] r_mul_a;
    logic [MUL_B_W-1:0] r_mul_b;
    logic               w_mul_done;
    logic [MUL_P_W-1:0] w_mul_prod;
    logic               r_div_start;
    logic [DIV_N_W-1:0] r_div_num;
    logic [DIV_D_W-1:0] r_div_den;
    logic               w_div_done;
    logic [DIV_N_W-1:0] w_div_quo;

    lvl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    lvl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // effective channel count and block length after limits
    logic [3:0]  w_nch;
    logic [12:0] w_blk;
    logic [16:0] w_target;
    logic        w_keep;
    logic [15:0] w_samp_u;
    logic [15:0] w_mag;
    logic [16:0] w_count_inc;
    logic        w_cfg_wr;

    assign w_nch = (r_num_ch == '0) ? 4'd1 :
                   (r_num_ch > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : r_num_ch;
    assign w_blk = (r_blk == '0) ? 13'd1 :
                   (r_blk > 13'(MAX_BLOCK)) ? 13'(MAX_BLOCK) : r_blk;
    // all channels: target spans every channel of the frame
    assign w_target = (r_sel_ch == '0) ? 17'(w_blk) * 17'(w_nch) : 17'(w_blk);
    // a selection beyond the channel count keeps every sample
    assign w_keep = (r_sel_ch == '0) || (r_sel_ch > w_nch) ||
                    ({1'b0, i_channel_index} == (r_sel_ch - 4'd1));
    assign w_samp_u    = i_sample;
    assign w_mag       = w_samp_u[15] ? (~w_samp_u + 16'd1) : w_samp_u;
    assign w_count_inc = {1'b0, r_count} + 17'd1;

    // smoothing terms for the level picked by r_which
    logic [14:0] w_raw;
    logic [14:0] w_held;
    logic [16:0] w_c;
    logic        w_sm_on;
    logic [32:0] w_sm_sum;

    assign w_raw    = r_which ? r_raw_rms : r_raw_pk;
    assign w_held   = r_which ? r_rms_held : r_pk_held;
    assign w_c      = (w_raw > w_held) ? coeff_sat(r_attack) : coeff_sat(r_release);
    assign w_sm_on  = r_smooth && (r_attack != '0) && (r_release != '0);
    assign w_sm_sum = {1'b0, r_tmp} + 33'(w_mul_prod) + 33'd32768;

    // digit-by-digit square root, two radicand bits per step
    logic [25:0] w_sq_t;
    logic [25:0] w_sq_trial;
    logic        w_sq_ge;
    logic [23:0] w_root_nx;

    assign w_sq_t     = {r_srem[23:0], r_rad[47:46]};
    assign w_sq_trial = {r_root, 2'b01};
    assign w_sq_ge    = w_sq_t >= w_sq_trial;
    assign w_root_nx  = {r_root[22:0], w_sq_ge};

    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch    <= 4'd2;
            r_sel_ch    <= '0;
            r_blk       <= 13'd1024;
            r_smooth    <= 1'b0;
            r_attack    <= '0;
            r_release   <= '0;
            r_state     <= S_IDLE;
            r_peak      <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_end       <= 1'b0;
            r_pk_held   <= '0;
            r_rms_held  <= '0;
            r_which     <= 1'b0;
            r_out_valid <= 1'b0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            if (w_cfg_wr) begin
                case (paddr[4:2])
                    REG_NUM_CH:  r_num_ch  <= pwdata[3:0];
                    REG_SEL_CH:  r_sel_ch  <= pwdata[3:0];
                    REG_BLOCK:   r_blk     <= pwdata[12:0];
                    REG_SMOOTH:  r_smooth  <= pwdata[0];
                    REG_ATTACK:  r_attack  <= pwdata[16:0];
                    REG_RELEASE: r_release <= pwdata[16:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && w_keep) begin
                        if (w_mag > r_peak) r_peak <= w_mag;
                        r_count     <= w_count_inc[15:0];
                        r_end       <= w_count_inc >= w_target;
                        r_mul_a     <= MUL_A_W'(w_mag);
                        r_mul_b     <= MUL_B_W'(w_mag);
                        r_mul_start <= 1'b1;
                        r_state     <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_mul_done) begin
                        r_sum <= r_sum + 46'(w_mul_prod);
                        if (r_end) begin
                            r_mul_a     <= MUL_A_W'(LVL_LIMIT);
                            r_mul_b     <= MUL_B_W'(r_peak);
                            r_mul_start <= 1'b1;
                            r_state     <= S_PMUL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PMUL: begin
                    if (w_mul_done) begin
                        r_div_num   <= DIV_N_W'(w_mul_prod) + DIV_N_W'(PK_HALF);
                        r_div_den   <= DIV_D_W'(FULL_SCALE);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_PK;
                    end
                end
                S_DIV_PK: begin
                    if (w_div_done) begin
                        r_raw_pk    <= w_div_quo[14:0];
                        // mean square in Q16
                        r_div_num   <= {r_sum, 16'd0};
                        r_div_den   <= DIV_D_W'(r_count);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_M;
                    end
                end
                S_DIV_M: begin
                    if (w_div_done) begin
                        r_rad   <= w_div_quo[47:0];
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_scnt  <= 5'd23;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= w_sq_ge ? (w_sq_t - w_sq_trial) : w_sq_t;
                    r_root <= w_root_nx;
                    r_rad  <= r_rad << 2;
                    r_scnt <= r_scnt - 5'd1;
                    if (r_scnt == '0) begin
                        r_mul_a     <= w_root_nx;
                        r_mul_b     <= MUL_B_W'(LVL_LIMIT);
                        r_mul_start <= 1'b1;
                        r_state     <= S_RMUL;
                    end
                end
                S_RMUL: begin
                    if (w_mul_done) begin
                        r_div_num   <= DIV_N_W'(w_mul_prod) + DIV_N_W'(RMS_HALF);
                        r_div_den   <= DIV_D_W'(RMS_DEN);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_RMS;
                    end
                end
                S_DIV_RMS: begin
                    if (w_div_done) begin
                        r_raw_rms <= w_div_quo[14:0];
                        r_which   <= 1'b0;
                        r_state   <= S_SM1;
                    end
                end
                S_SM1: begin
                    if (w_sm_on) begin
                        r_c         <= 17'h10000 - w_c;
                        r_mul_a     <= MUL_A_W'(w_raw);
                        r_mul_b     <= w_c;
                        r_mul_start <= 1'b1;
                        r_state     <= S_SM2;
                    end else begin
                        // no smoothing: the raw level goes straight through the clamp
                        if (r_which) r_rms_held <= lvl_clamp({2'b00, w_raw});
                        else         r_pk_held  <= lvl_clamp({2'b00, w_raw});
                        r_which <= 1'b1;
                        r_state <= r_which ? S_OUT : S_SM1;
                    end
                end
                S_SM2: begin
                    if (w_mul_done) begin
                        r_tmp       <= w_mul_prod[31:0];
                        r_mul_a     <= MUL_A_W'(w_held);
                        r_mul_b     <= r_c;
                        r_mul_start <= 1'b1;
                        r_state     <= S_SM3;
                    end
                end
                S_SM3: begin
                    if (w_mul_done) begin
                        if (r_which) r_rms_held <= lvl_clamp(w_sm_sum[32:16]);
                        else         r_pk_held  <= lvl_clamp(w_sm_sum[32:16]);
                        r_which <= 1'b1;
                        r_state <= r_which ? S_OUT : S_SM1;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_peak_out  <= r_pk_held;
                        r_rms_out   <= r_rms_held;
                        r_peak      <= '0;
                        r_sum       <= '0;
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_NUM_CH:  prdata = {28'd0, r_num_ch};
            REG_SEL_CH:  prdata = {28'd0, r_sel_ch};
            REG_BLOCK:   prdata = {19'd0, r_blk};
            REG_SMOOTH:  prdata = {31'd0, r_smooth};
            REG_ATTACK:  prdata = {15'd0, r_attack};
            REG_RELEASE: prdata = {15'd0, r_release};
            default:     prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_peak_level = r_peak_out;
    assign o_rms_level  = r_rms_out;

endmodule

@@ hdl/lvl_chk.sv @@
module lvl_chk import lvl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [14:0] o_peak_level,
    input logic [14:0] o_rms_level
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_peak_level)
        && $stable(o_rms_level))
        else $error("result beat changed while stalled");

    // both levels are clamped at full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_level <= 15'(LVL_LIMIT)) && (o_rms_level <= 15'(LVL_LIMIT)))
        else $error("level above full scale");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a new result is loaded only while input is held off
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result loaded while input was open");

endmodule

bind block_peak_rms_level_meter_top lvl_chk u_lvl_chk (.*);

@@ tb/sv/tb_block_peak_rms_level_meter_top.sv @@
`timescale 1ns / 1ps

// keeps the meter's running state and a queue of expected level pairs
class level_scoreboard;
    int unsigned nch_reg;
    int unsigned sel_reg;
    int unsigned blk_reg;
    bit          smooth_reg;
    longint unsigned atk_reg;
    longint unsigned rel_reg;

    longint unsigned peak_acc;
    longint unsigned sq_sum;
    longint unsigned kept;
    longint unsigned peak_held;
    longint unsigned rms_held;

    logic [14:0] exp_peak_q[$];
    logic [14:0] exp_rms_q[$];
    int          err_count;

    function new();
        nch_reg = 2; sel_reg = 0; blk_reg = 1024; smooth_reg = 0;
        atk_reg = 0; rel_reg = 0;
        peak_acc = 0; sq_sum = 0; kept = 0; peak_held = 0; rms_held = 0;
        err_count = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            lvl_pkg::REG_NUM_CH:  nch_reg = val[3:0];
            lvl_pkg::REG_SEL_CH:  sel_reg = val[3:0];
            lvl_pkg::REG_BLOCK:   blk_reg = val[12:0];
            lvl_pkg::REG_SMOOTH:  smooth_reg = val[0];
            lvl_pkg::REG_ATTACK:  atk_reg = val[16:0];
            lvl_pkg::REG_RELEASE: rel_reg = val[16:0];
            default: ;
        endcase
    endfunction

    function longint unsigned isqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function longint unsigned blend_level(longint unsigned raw, longint unsigned held);
        longint unsigned a, r, c, v;
        a = (atk_reg > 65536) ? 65536 : atk_reg;
        r = (rel_reg > 65536) ? 65536 : rel_reg;
        v = raw;
        if (smooth_reg && a != 0 && r != 0) begin
            c = (raw > held) ? a : r;
            v = (c * raw + (65536 - c) * held + 32768) >> 16;
        end
        return (v > lvl_pkg::LVL_LIMIT) ? lvl_pkg::LVL_LIMIT : v;
    endfunction

    // returns 1 when this sample closes a block
    function bit note_sample(logic signed [15:0] smp, logic [2:0] ch);
        longint unsigned nch, blk, target, mag, lim, raw_pk, m, raw_rms, den;
        bit keep;
        nch = (nch_reg == 0) ? 1 : (nch_reg > lvl_pkg::MAX_CHANNELS) ?
              lvl_pkg::MAX_CHANNELS : nch_reg;
        blk = (blk_reg == 0) ? 1 : (blk_reg > lvl_pkg::MAX_BLOCK) ?
              lvl_pkg::MAX_BLOCK : blk_reg;
        mag = (smp < 0) ? -longint'(smp) : longint'(smp);
        if (sel_reg == 0) begin
            keep = 1; target = blk * nch;
        end else if (sel_reg > nch) begin
            keep = 1; target = blk;
        end else begin
            keep = (ch == sel_reg - 1); target = blk;
        end
        if (!keep) return 0;
        if (mag > peak_acc) peak_acc = mag;
        sq_sum += mag * mag;
        kept += 1;
        if (kept < target) return 0;
        lim = lvl_pkg::LVL_LIMIT;
        raw_pk = (peak_acc * lim + lvl_pkg::FULL_SCALE / 2) / lvl_pkg::FULL_SCALE;
        m = (sq_sum << 16) / kept;
        den = longint'(lvl_pkg::FULL_SCALE) << 8;
        raw_rms = (isqrt(m) * lim + den / 2) / den;
        peak_held = blend_level(raw_pk, peak_held);
        rms_held = blend_level(raw_rms, rms_held);
        peak_acc = 0; sq_sum = 0; kept = 0;
        exp_peak_q = {exp_peak_q, peak_held[14:0]};
        exp_rms_q = {exp_rms_q, rms_held[14:0]};
        return 1;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    task check_levels(logic [14:0] pk, logic [14:0] rms);
        logic [14:0] ep, er;
        if (exp_peak_q.size() == 0) begin
            report($sformatf("unexpected result peak=%0d rms=%0d", pk, rms));
            return;
        end
        ep = exp_peak_q.pop_front();
        er = exp_rms_q.pop_front();
        if (pk !== ep) report($sformatf("peak_level got %0d want %0d", pk, ep));
        if (rms !== er) report($sformatf("rms_level got %0d want %0d", rms, er));
    endtask
endclass

module tb_block_peak_rms_level_meter_top;
    import lvl_pkg::*;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [15:0]       i_sample;
    logic [2:0]               i_channel_index;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [14:0]              o_peak_level;
    logic [14:0]              o_rms_level;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    level_scoreboard sb;
    // idle-cycle bound for the consumer; zero gives a stretch with no stalls
    int unsigned out_gap_max;
    int unsigned stall_cycles;

    localparam int WATCHDOG_LIMIT = 4000;

    block_peak_rms_level_meter_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .i_channel_index (i_channel_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_peak_level    (o_peak_level),
        .o_rms_level     (o_rms_level),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stall per beat, check on every accepted beat
    initial begin
        int unsigned gap;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                sb.check_levels(o_peak_level, o_rms_level);
                gap = (out_gap_max == 0) ? 0 : $urandom_range(out_gap_max, 0);
                if (gap != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
            end else if (!i_out_ready && i_rst_n) begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any beat on either channel
    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // one sample beat, with a random lead-in gap
    task automatic send_sample(input logic signed [15:0] smp, input logic [2:0] ch,
                               input int unsigned gap_max);
        int unsigned gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample        <= smp;
        i_channel_index <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        void'(sb.note_sample(smp, ch));
    endtask

    task automatic end_of_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait out pending results, then the block's trailing work, before config
    task automatic drain();
        end_of_input();
        while (sb.exp_peak_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_all(input int unsigned nch, input int unsigned sel,
                           input int unsigned blk, input bit sm,
                           input int unsigned atk, input int unsigned rel);
        apb_write(REG_NUM_CH, nch);
        apb_write(REG_SEL_CH, sel);
        apb_write(REG_BLOCK, blk);
        apb_write(REG_SMOOTH, 32'(sm));
        apb_write(REG_ATTACK, atk);
        apb_write(REG_RELEASE, rel);
    endtask

    // quiet, mid-level or fully random audio, sometimes full scale
    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(3, 0))
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(200, 0))) - 16'sd100;
            2: return ($urandom_range(1, 0)) ? 16'sh8000 : 16'sh7fff;
            default: return $signed(16'($urandom_range(16000, 0))) - 16'sd8000;
        endcase
    endfunction

    // random phase: frames in channel order with the odd stray index
    task automatic random_phase(input int unsigned items, input int unsigned gap_max);
        int unsigned nch;
        logic [2:0]  ch;
        nch = (sb.nch_reg == 0) ? 1 : (sb.nch_reg > 8) ? 8 : sb.nch_reg;
        ch = 0;
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(9, 0) == 0)
                send_sample(rand_sample(), 3'($urandom), gap_max);
            else begin
                send_sample(rand_sample(), ch, gap_max);
                ch = (ch + 1 >= nch) ? 3'd0 : ch + 3'd1;
            end
        end
    endtask

    initial begin
        sb = new();
        out_gap_max  = 10;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        i_channel_index = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one channel, block of one, field extremes
        set_all(1, 0, 1, 0, 0, 0);
        send_sample(16'sh7fff, 3'd0, 0);
        send_sample(16'sh8000, 3'd7, 3);
        send_sample(16'sh0000, 3'd0, 0);
        send_sample(16'sh0001, 3'd5, 0);
        send_sample(-16'sd1, 3'd2, 0);
        drain();

        // smoothing with full and minimal coefficients, rising then falling
        set_all(1, 0, 1, 1, 65536, 1);
        send_sample(16'sh4000, 3'd0, 0);
        send_sample(16'sh8000, 3'd0, 0);
        send_sample(16'sh0000, 3'd0, 0);
        send_sample(16'sh0010, 3'd0, 0);
        drain();
        // coefficients above 1.0 saturate, max register bits
        set_all(8, 0, 1, 1, 32'h1ffff, 32'h1ffff);
        for (int k = 0; k < 8; k++) send_sample(16'sh7fff, 3'(k), 0);
        drain();

        // channel select, bad selection and unreachable channel
        set_all(3, 2, 2, 0, 0, 0);
        for (int k = 0; k < 6; k++) send_sample(16'(1000 * k), 3'(k % 3), 1);
        drain();
        set_all(2, 5, 2, 0, 0, 0);
        for (int k = 0; k < 2; k++) send_sample(-16'sd300, 3'(k), 0);
        drain();
        set_all(15, 15, 0, 0, 0, 0);
        for (int k = 0; k < 3; k++) send_sample(16'sd77, 3'(k), 0);
        drain();

        // shrink target mid-block
        set_all(1, 0, 8, 0, 0, 0);
        for (int k = 0; k < 5; k++) send_sample(16'sd5000, 3'd0, 0);
        drain();
        apb_write(REG_BLOCK, 2);
        send_sample(16'sd100, 3'd0, 0);
        drain();

        // random phases across settings; the first runs with no idling
        out_gap_max = 0;
        set_all(2, 0, 3, 1, 20000, 3000);
        random_phase(120, 0);
        drain();
        out_gap_max = 10;
        set_all(4, 3, 4, 1, $urandom_range(65536, 1), $urandom_range(65536, 1));
        random_phase(150, 10);
        drain();
        set_all(1, 1, 5, 0, 0, 0);
        random_phase(150, 10);
        drain();
        set_all(8, 0, 2, 1, 0, 4000);
        random_phase(150, 10);
        drain();
        set_all(3, 0, 4096, 0, 0, 0);
        random_phase(40, 2);
        drain();
        set_all(6, 0, 8191, 1, 65536, 65536);
        random_phase(20, 2);
        drain();
        set_all(5, 2, 1, 1, $urandom_range(65536, 1), $urandom_range(65536, 1));
        random_phase(200, 10);
        drain();

        if (sb.exp_peak_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.exp_peak_q.size()));
        if (sb.err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ block_peak_rms_level_meter_top.f @@
hdl/lvl_pkg.sv
hdl/lvl_mul.sv
hdl/lvl_div.sv
hdl/block_peak_rms_level_meter_top.sv
hdl/lvl_chk.sv
tb/sv/tb_block_peak_rms_level_meter_top.sv
